FILE: rtl/banded_sphere_pixel_shader_unit_macros.svh
// ---------------------------------------------------------------------------
// banded sphere pixel shader assertion macros
// shared assertion forms for the shader checker
// ---------------------------------------------------------------------------
`ifndef BANDED_SPHERE_PIXEL_SHADER_UNIT_MACROS_SVH
`define BANDED_SPHERE_PIXEL_SHADER_UNIT_MACROS_SVH

// property checked only outside reset
`define BSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define BSPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bsps_pkg.sv
// ---------------------------------------------------------------------------
// bsps_pkg
// constants, tables and types of the banded sphere pixel shader
// ---------------------------------------------------------------------------
package bsps_pkg;

  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 272;
  localparam int SPHERE_RADIUS = 105;
  localparam int BAND_STEPS    = 64;

  localparam int ROWS      = 2 * SPHERE_RADIUS + 1;
  localparam int RAD2      = SPHERE_RADIUS * SPHERE_RADIUS;
  localparam int CEN_X     = SCREEN_WIDTH / 2;
  localparam int CEN_Y     = SCREEN_HEIGHT / 2 - 10;
  localparam int ONE       = 1024;
  localparam int AMBIENT   = 64;
  localparam int NRM_SH    = 20;
  localparam int NRM_MUL   = (1 << NRM_SH) / (SPHERE_RADIUS << 2);
  localparam int SPEC_KNEE = ONE / 4;
  localparam int SPEC_R    = 200;
  localparam int SPEC_G    = 180;
  localparam int SPEC_B    = 140;
  localparam int RIM_DEPTH = SPHERE_RADIUS / 3;
  localparam int BAND_IDX_W = $clog2(BAND_STEPS);

  // red spot
  localparam int SPOT_LAT_NEAR = ONE * 20 / 100;
  localparam int SPOT_LAT_FAR  = ONE * 34 / 100;
  localparam int SPOT_LAT_MID  = ONE * 27 / 100;
  localparam int SPOT_LON      = 80;
  localparam int SPOT_HALF     = 18;
  localparam int SPOT_ED_CORE  = 80;
  localparam int SPOT_ED_MID   = 140;
  localparam int SPOT_ED_EDGE  = 200;
  localparam logic [23:0] SPOT_CORE_COLOR = 24'hB44128;
  localparam logic [23:0] SPOT_MID_COLOR  = 24'hC3502D;
  localparam logic [23:0] SPOT_EDGE_COLOR = 24'hD2693C;

  // register map
  localparam logic REG_FRAME_INDEX = 1'b0;

  typedef logic [6:0]  hw_tab_t   [0:ROWS-1];
  typedef logic [23:0] step_tab_t [0:ROWS-1];
  typedef logic [10:0] alat_tab_t [0:SPHERE_RADIUS];
  typedef logic [23:0] band_tab_t [0:BAND_STEPS-1];

  typedef struct packed {
    logic signed [13:0] lx;
    logic signed [11:0] ly;
    logic signed [13:0] lz;
    logic [7:0]         lon_off;
  } light_t;

  function automatic logic [31:0] isqrt_c(input logic [31:0] v_in);
    logic [31:0] v;
    logic [31:0] r;
    logic [31:0] b;
    v = v_in;
    r = '0;
    b = 32'h4000_0000;
    for (int i = 0; i < 16; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // shift-subtract quotient, elaboration only
  function automatic logic [31:0] udiv_c(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] q;
    logic [32:0] rm;
    q  = '0;
    rm = '0;
    for (int i = 31; i >= 0; i--) begin
      rm = {rm[31:0], n[i]};
      if (rm >= {1'b0, d}) begin
        rm   = rm - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [31:0] row_hw_c(input int i);
    int dy;
    int rem;
    dy  = i - SPHERE_RADIUS;
    rem = RAD2 - dy * dy;
    return (rem > 0) ? isqrt_c(32'(rem)) : 32'd0;
  endfunction

  function automatic hw_tab_t make_hw_tab();
    hw_tab_t t;
    for (int i = 0; i < ROWS; i++) t[i] = 7'(row_hw_c(i));
    return t;
  endfunction

  function automatic step_tab_t make_step_tab();
    step_tab_t t;
    logic [31:0] hw;
    for (int i = 0; i < ROWS; i++) begin
      hw   = row_hw_c(i);
      t[i] = (hw != 0) ? 24'(udiv_c(32'h0100_0000, hw << 1)) : 24'd0;
    end
    return t;
  endfunction

  function automatic alat_tab_t make_alat_tab();
    alat_tab_t t;
    for (int i = 0; i <= SPHERE_RADIUS; i++) t[i] = 11'((i * ONE) / SPHERE_RADIUS);
    return t;
  endfunction

  function automatic band_tab_t make_band_tab();
    band_tab_t t;
    int a;
    for (int i = 0; i < BAND_STEPS; i++) begin
      a = (i * ONE) / BAND_STEPS;
      if      (a < ONE * 8 / 100)  t[i] = 24'hEBD7AF;
      else if (a < ONE * 16 / 100) t[i] = 24'hAA7346;
      else if (a < ONE * 24 / 100) t[i] = 24'hE1CDA5;
      else if (a < ONE * 35 / 100) t[i] = 24'hA07850;
      else if (a < ONE * 50 / 100) t[i] = 24'hD7C8AA;
      else if (a < ONE * 62 / 100) t[i] = 24'hAF916E;
      else if (a < ONE * 78 / 100) t[i] = 24'hBEB4A5;
      else                         t[i] = 24'h9B9BAA;
    end
    return t;
  endfunction

  localparam hw_tab_t   HW_TAB   = make_hw_tab();
  localparam step_tab_t STEP_TAB = make_step_tab();
  localparam alat_tab_t ALAT_TAB = make_alat_tab();
  localparam band_tab_t BAND_TAB = make_band_tab();

endpackage

FILE: rtl/banded_sphere_pixel_shader_unit.sv
// ---------------------------------------------------------------------------
// banded_sphere_pixel_shader_unit
// shades one pixel of a banded, lit sphere per item
// ---------------------------------------------------------------------------
// One pixel coordinate in, one color out. The block runs as an eight stage
// pipeline and takes one item per clock while the output does not stall;
// each item passes through the stage registers in order. Every stage has its
// own valid bit and holds only when the stages ahead are full, so bubbles
// close up and a stalled output register blocks items entering only once
// every stage is full. The depth square root is split over stages two and
// three. frame_index is read through a registered light stage, so it should
// be written while no item is in flight. Pixels off the sphere come out with
// pixel_drawn low and a zero color.
module banded_sphere_pixel_shader_unit import bsps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_x [8:0], pixel_y [17:9], zero pad
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_color [23:0]
  output logic [0:0]  out_tuser,  // pixel_drawn [0]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NS = 8;

  // ---------------- configuration ----------------
  logic [30:0] frame_r;
  light_t      light;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_FRAME_INDEX) begin
      frame_r <= cfg_pwdata[30:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FRAME_INDEX) ? {1'b0, frame_r} : 32'd0;

  bsps_light u_light (
    .clk         (clk),
    .frame_index (frame_r),
    .light_r     (light)
  );

  // ---------------- pipeline control ----------------
  logic [NS:1] v_r;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v_r[NS] || out_tready;
    for (int k = NS - 1; k >= 1; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_tready  = en[1];
  assign out_tvalid = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_tvalid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---------------- stage 1: offsets, row tables, radius squared ----------------
  logic [10:0] ix_w, iy_w;
  logic        ok_w;
  logic [7:0]  row_w;
  logic signed [7:0]  dx_w, dy_w;
  logic signed [15:0] dxsq_w, dysq_w;
  logic [6:0]  ady_w;

  assign ix_w = 11'(in_tdata[8:0]) + 11'(SPHERE_RADIUS) - 11'(CEN_X);
  assign iy_w = 11'(in_tdata[17:9]) + 11'(SPHERE_RADIUS) - 11'(CEN_Y);
  assign ok_w = (in_tdata[8:0] < 9'(SCREEN_WIDTH)) && (in_tdata[17:9] < 9'(SCREEN_HEIGHT)) &&
                (ix_w <= 11'(2 * SPHERE_RADIUS)) && (iy_w <= 11'(2 * SPHERE_RADIUS));
  assign row_w  = ok_w ? iy_w[7:0] : 8'd0;
  assign dx_w   = $signed(ix_w[7:0] - 8'(SPHERE_RADIUS));
  assign dy_w   = $signed(iy_w[7:0] - 8'(SPHERE_RADIUS));
  assign dxsq_w = dx_w * dx_w;
  assign dysq_w = dy_w * dy_w;
  assign ady_w  = dy_w[7] ? 7'(-dy_w) : 7'(dy_w);

  logic               s1_ok_r;
  logic signed [7:0]  s1_dx_r, s1_dy_r;
  logic [14:0]        s1_d2_r;
  logic [6:0]         s1_hw_r;
  logic [23:0]        s1_step_r;
  logic [10:0]        s1_alat_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ok_r   <= ok_w;
      s1_dx_r   <= dx_w;
      s1_dy_r   <= dy_w;
      s1_d2_r   <= 15'(dxsq_w + dysq_w);
      s1_hw_r   <= HW_TAB[row_w];
      s1_step_r <= STEP_TAB[row_w];
      s1_alat_r <= ok_w ? ALAT_TAB[ady_w] : 11'd0;
    end
  end

  // ---------------- stage 2: root upper steps, latitude ----------------
  logic [13:0] sq2_v_nxt, sq2_r_nxt, sq2_b;
  logic [16:0] idxp_w;
  logic [6:0]  idx_full_w;
  logic [BAND_IDX_W-1:0] band_idx_w;
  logic signed [11:0] lat_w;
  logic        spot_row_w;

  always_comb begin
    sq2_v_nxt = (s1_ok_r && s1_d2_r <= 15'(RAD2)) ? 14'(15'(RAD2) - s1_d2_r) : 14'd0;
    sq2_r_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      sq2_b = 14'd1 << (12 - 2 * i);
      if ({1'b0, sq2_v_nxt} >= 15'(sq2_r_nxt) + 15'(sq2_b)) begin
        sq2_v_nxt = sq2_v_nxt - (sq2_r_nxt + sq2_b);
        sq2_r_nxt = (sq2_r_nxt >> 1) + sq2_b;
      end else begin
        sq2_r_nxt = sq2_r_nxt >> 1;
      end
    end
  end

  assign idxp_w     = 17'(s1_alat_r) * 17'(BAND_STEPS);
  assign idx_full_w = idxp_w[16:10];
  assign band_idx_w = (idx_full_w >= 7'(BAND_STEPS)) ? BAND_IDX_W'(BAND_STEPS - 1)
                                                    : idx_full_w[BAND_IDX_W-1:0];
  assign lat_w      = s1_dy_r[7] ? -$signed({1'b0, s1_alat_r}) : $signed({1'b0, s1_alat_r});
  // spot sits on a latitude strip south of the equator
  assign spot_row_w = s1_dy_r[7] && (s1_alat_r > 11'(SPOT_LAT_NEAR)) &&
                      (s1_alat_r < 11'(SPOT_LAT_FAR));

  logic               s2_ok_r, s2_spot_r;
  logic signed [7:0]  s2_dx_r, s2_dy_r;
  logic [13:0]        s2_sqv_r, s2_sqr_r;
  logic [6:0]         s2_hw_r;
  logic [23:0]        s2_step_r, s2_band_r;
  logic signed [11:0] s2_dlat_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_ok_r   <= s1_ok_r;
      s2_spot_r <= spot_row_w;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_sqv_r  <= sq2_v_nxt;
      s2_sqr_r  <= sq2_r_nxt;
      s2_hw_r   <= s1_hw_r;
      s2_step_r <= s1_step_r;
      s2_band_r <= BAND_TAB[band_idx_w];
      s2_dlat_r <= lat_w + 12'(SPOT_LAT_MID);
    end
  end

  // ---------------- stage 3: root lower steps, spot distance, longitude ----------------
  logic [13:0] sq3_v_nxt, sq3_r_nxt, sq3_b;
  logic signed [23:0] dlat_sq_w;
  logic [7:0]  lsum_w;
  logic [31:0] lprod_w;

  always_comb begin
    sq3_v_nxt = s2_sqv_r;
    sq3_r_nxt = s2_sqr_r;
    for (int i = 0; i < 3; i++) begin
      sq3_b = 14'd1 << (4 - 2 * i);
      if ({1'b0, sq3_v_nxt} >= 15'(sq3_r_nxt) + 15'(sq3_b)) begin
        sq3_v_nxt = sq3_v_nxt - (sq3_r_nxt + sq3_b);
        sq3_r_nxt = (sq3_r_nxt >> 1) + sq3_b;
      end else begin
        sq3_r_nxt = sq3_r_nxt >> 1;
      end
    end
  end

  assign dlat_sq_w = s2_dlat_r * s2_dlat_r;
  assign lsum_w    = 8'(s2_dx_r) + 8'(s2_hw_r);
  assign lprod_w   = 32'(lsum_w) * 32'(s2_step_r);

  logic               s3_ok_r, s3_spot_r;
  logic signed [7:0]  s3_dx_r, s3_dy_r;
  logic [6:0]         s3_nz_r, s3_hw_r;
  logic [23:0]        s3_band_r;
  logic [12:0]        s3_ey_r;
  logic [7:0]         s3_lon_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_ok_r   <= s2_ok_r;
      s3_spot_r <= s2_spot_r;
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
      s3_nz_r   <= sq3_r_nxt[6:0];
      s3_hw_r   <= s2_hw_r;
      s3_band_r <= s2_band_r;
      s3_ey_r   <= dlat_sq_w[20:8];
      s3_lon_r  <= lprod_w[23:16] + light.lon_off;
    end
  end

  // ---------------- stage 4: light products, base color, rim ----------------
  logic signed [7:0]  dl_w;
  logic signed [15:0] dlsq_w;
  logic [15:0] ed_w;
  logic        in_spot_w;
  logic [23:0] base_w;
  logic [5:0]  gap_w;
  logic [7:0]  gap3_w;

  assign dl_w      = $signed(s3_lon_r - 8'(SPOT_LON));
  assign dlsq_w    = dl_w * dl_w;
  assign ed_w      = 16'(dlsq_w) + 16'(s3_ey_r);
  assign in_spot_w = s3_spot_r && (dl_w > -8'sd18) && (dl_w < 8'(SPOT_HALF)) &&
                     (ed_w < 16'(SPOT_ED_EDGE));

  always_comb begin
    if (!in_spot_w) begin
      base_w = s3_band_r;
    end else if (ed_w < 16'(SPOT_ED_CORE)) begin
      base_w = SPOT_CORE_COLOR;
    end else if (ed_w < 16'(SPOT_ED_MID)) begin
      base_w = SPOT_MID_COLOR;
    end else begin
      base_w = SPOT_EDGE_COLOR;
    end
  end

  // rim glow grows toward the limb
  assign gap_w  = (s3_nz_r < 7'(RIM_DEPTH)) ? 6'(7'(RIM_DEPTH) - s3_nz_r) : 6'd0;
  assign gap3_w = 8'(gap_w) * 8'd3;

  logic               s4_drawn_r;
  logic signed [21:0] s4_px_r, s4_pz_r;
  logic signed [19:0] s4_py_r;
  logic [23:0]        s4_base_r;
  logic [5:0]         s4_rim_g_r, s4_rim_b_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_drawn_r <= s3_ok_r && (s3_nz_r != 7'd0) && (s3_hw_r != 7'd0);
      s4_px_r    <= s3_dx_r * light.lx;
      s4_py_r    <= s3_dy_r * light.ly;
      s4_pz_r    <= $signed({1'b0, s3_nz_r}) * light.lz;
      s4_base_r  <= base_w;
      s4_rim_g_r <= 6'(gap3_w >> 2);
      s4_rim_b_r <= 6'(gap3_w >> 1);
    end
  end

  // ---------------- stage 5: dot product and normalize ----------------
  logic signed [22:0] dot_w;
  logic signed [35:0] nprod_w;

  assign dot_w   = 23'(s4_px_r) + 23'(s4_py_r) + 23'(s4_pz_r);
  assign nprod_w = dot_w * $signed(13'(NRM_MUL));

  logic               s5_drawn_r;
  logic signed [12:0] s5_diff_r;
  logic [23:0]        s5_base_r;
  logic [5:0]         s5_rim_g_r, s5_rim_b_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_drawn_r <= s4_drawn_r;
      s5_diff_r  <= nprod_w[32:20];
      s5_base_r  <= s4_base_r;
      s5_rim_g_r <= s4_rim_g_r;
      s5_rim_b_r <= s4_rim_b_r;
    end
  end

  // ---------------- stage 6: diffuse level, first specular square ----------------
  logic [21:0] dterm_w;
  logic [12:0] lit_sum_w;
  logic [10:0] lit_w;
  logic        spec_on_w;
  logic [11:0] s1_w;
  logic [23:0] s1sq_w;

  assign dterm_w   = 22'(ONE - AMBIENT) * 22'(s5_diff_r[11:0]);
  assign lit_sum_w = 13'(AMBIENT) + 13'(dterm_w[21:10]);
  always_comb begin
    if (s5_diff_r <= 13'sd0) begin
      lit_w = 11'(AMBIENT);
    end else if (lit_sum_w > 13'(ONE)) begin
      lit_w = 11'(ONE);
    end else begin
      lit_w = lit_sum_w[10:0];
    end
  end
  assign spec_on_w = s5_diff_r > $signed(13'(SPEC_KNEE));
  assign s1_w      = spec_on_w ? 12'(s5_diff_r - $signed(13'(SPEC_KNEE))) : 12'd0;
  assign s1sq_w    = 24'(s1_w) * 24'(s1_w);

  logic        s6_drawn_r;
  logic [10:0] s6_lit_r;
  logic [13:0] s6_sq1_r;
  logic [23:0] s6_base_r;
  logic [5:0]  s6_rim_g_r, s6_rim_b_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_drawn_r <= s5_drawn_r;
      s6_lit_r   <= lit_w;
      s6_sq1_r   <= s1sq_w[23:10];
      s6_base_r  <= s5_base_r;
      s6_rim_g_r <= s5_rim_g_r;
      s6_rim_b_r <= s5_rim_b_r;
    end
  end

  // ---------------- stage 7: scale by light, second specular square ----------------
  logic [18:0] lr_w, lg_w, lb_w;
  logic [27:0] s2sq_w;

  assign lr_w   = 19'(s6_base_r[23:16]) * 19'(s6_lit_r);
  assign lg_w   = 19'(s6_base_r[15:8]) * 19'(s6_lit_r);
  assign lb_w   = 19'(s6_base_r[7:0]) * 19'(s6_lit_r);
  assign s2sq_w = 28'(s6_sq1_r) * 28'(s6_sq1_r);

  logic        s7_drawn_r;
  logic [7:0]  s7_r_r, s7_g_r, s7_b_r;
  logic [17:0] s7_spec_r;
  logic [5:0]  s7_rim_g_r, s7_rim_b_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_drawn_r <= s6_drawn_r;
      s7_r_r     <= lr_w[17:10];
      s7_g_r     <= lg_w[17:10];
      s7_b_r     <= lb_w[17:10];
      s7_spec_r  <= s2sq_w[27:10];
      s7_rim_g_r <= s6_rim_g_r;
      s7_rim_b_r <= s6_rim_b_r;
    end
  end

  // ---------------- stage 8: highlight, rim, saturate, output register ----------------
  logic [25:0] hr_w, hg_w, hb_w;
  logic [16:0] sr_w, sg_w, sb_w;
  logic [7:0]  cr_w, cg_w, cb_w;

  assign hr_w = 26'(s7_spec_r) * 26'(SPEC_R);
  assign hg_w = 26'(s7_spec_r) * 26'(SPEC_G);
  assign hb_w = 26'(s7_spec_r) * 26'(SPEC_B);
  assign sr_w = 17'(s7_r_r) + 17'(hr_w[25:10]);
  assign sg_w = 17'(s7_g_r) + 17'(hg_w[25:10]) + 17'(s7_rim_g_r);
  assign sb_w = 17'(s7_b_r) + 17'(hb_w[25:10]) + 17'(s7_rim_b_r);
  assign cr_w = (sr_w > 17'd255) ? 8'd255 : sr_w[7:0];
  assign cg_w = (sg_w > 17'd255) ? 8'd255 : sg_w[7:0];
  assign cb_w = (sb_w > 17'd255) ? 8'd255 : sb_w[7:0];

  logic [23:0] color_r;
  logic        drawn_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      color_r <= s7_drawn_r ? {cr_w, cg_w, cb_w} : 24'd0;
      drawn_r <= s7_drawn_r;
    end
  end

  assign out_tdata = color_r;
  assign out_tuser = drawn_r;

endmodule

FILE: rtl/bsps_light.sv
// ---------------------------------------------------------------------------
// bsps_light
// light direction and longitude offset from the frame number, registered
// ---------------------------------------------------------------------------
module bsps_light import bsps_pkg::*; (
  input  logic        clk,
  input  logic [30:0] frame_index,
  output light_t      light_r
);

  function automatic logic signed [13:0] sine12(input logic [7:0] a);
    logic [6:0]  j;
    logic [13:0] v;
    j = a[6:0];
    v = 14'(j) * (14'd128 - 14'(j));
    return a[7] ? -$signed(v) : $signed(v);
  endfunction

  logic [23:0] q_w;
  logic [5:0]  dsum_w;
  logic [11:0] s43_w;
  logic [7:0]  q3x_w;
  logic [5:0]  q3_w;
  logic [9:0]  rem768_w;
  logic [19:0] third_w;
  logic signed [13:0] ly_full_w;
  light_t      light_nxt;

  // (frame / 3) mod 256 from frame mod 768; frame[30:8] mod 3 by digit sum
  always_comb begin
    q_w    = {1'b0, frame_index[30:8]};
    dsum_w = '0;
    for (int i = 0; i < 12; i++) dsum_w = dsum_w + 6'(q_w[2*i +: 2]);
    s43_w = 12'(dsum_w) * 12'd43;
    q3x_w = 8'(s43_w[11:7]) * 8'd3;
    q3_w  = dsum_w - q3x_w[5:0];
    rem768_w = {q3_w[1:0], frame_index[7:0]};
    third_w  = 20'(rem768_w) * 20'd683;
    ly_full_w = sine12(third_w[18:11]);
    light_nxt.lx      = sine12(frame_index[7:0] + 8'd64);
    light_nxt.lz      = sine12(frame_index[7:0]);
    light_nxt.ly      = 12'(ly_full_w >>> 2);
    light_nxt.lon_off = frame_index[8:1];
  end

  always_ff @(posedge clk) begin
    light_r <= light_nxt;
  end

endmodule

FILE: rtl/bsps_checker.sv
// ---------------------------------------------------------------------------
// bsps_checker
// port-level checks of the banded sphere pixel shader
// ---------------------------------------------------------------------------
`include "banded_sphere_pixel_shader_unit_macros.svh"

module bsps_sva_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a held result keeps its payload
  `BSPS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // pipeline empties on reset
  `BSPS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result present after reset")

  // undrawn pixels carry a black color
  `BSPS_ASSERT(a_undrawn_black, out_tvalid && !out_tuser[0] |-> out_tdata == 24'd0, "undrawn pixel with color")

  // input only blocks when every stage up to the output is full
  `BSPS_ASSERT(a_block_cause, !in_tready |-> out_tvalid && !out_tready, "input blocked without output stall")

endmodule

bind banded_sphere_pixel_shader_unit bsps_sva_checker u_bsps_checker (.*);
